// ===== hw/rtl/cct_pkg.sv =====
package cct_pkg;

  // store geometry: a power of two so that folding is a mask
  localparam int STORE_AW    = 16;
  localparam int STORE_BYTES = 1 << STORE_AW;

  // input item opcodes
  localparam logic OP_MARK    = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // what the back end does with a queued command
  typedef enum logic [1:0] {
    K_MARK  = 2'd0,   // write one length byte
    K_WALK  = 2'd1,   // walk the store from start to stop
    K_FIXED = 2'd2    // result known up front, nothing covered
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [STORE_AW-1:0]  addr;     // mark address or walk start
    logic [7:0]           len;
    logic [31:0]          stop;     // inclusive region end, folded in paged mode
    logic [32:0]          region;   // region size
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/cct_front.sv =====
module cct_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            paged_mode,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            opcode,
  input  logic [31:0]     address,
  input  logic [7:0]      op_length,
  input  logic [31:0]     region_end,
  input  cct_pkg::q_stat_t q_stat,
  input  logic            clearing,
  output logic            push,
  output cct_pkg::entry_t push_entry
);
  import cct_pkg::*;

  logic        paged;
  logic [31:0] start_f;
  logic [31:0] stop_f;
  logic        reversed;
  logic        start_in;

  // mode register, writable at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      paged <= 1'b0;
    end else if (cfg_valid) begin
      paged <= paged_mode;
    end
  end

  // address folding in paged mode
  always_comb begin
    start_f = address;
    stop_f  = region_end;
    if (paged) begin
      start_f = {{(32-STORE_AW){1'b0}}, address[STORE_AW-1:0]};
      stop_f  = {{(32-STORE_AW){1'b0}}, region_end[STORE_AW-1:0]};
    end
  end

  assign reversed = stop_f < start_f;
  assign start_in = start_f[31:STORE_AW] == '0;

  // classify the beat into a queue entry
  always_comb begin
    push_entry.addr   = start_f[STORE_AW-1:0];
    push_entry.len    = op_length;
    push_entry.stop   = stop_f;
    push_entry.region = reversed ? 33'd0
                                 : ({1'b0, stop_f} - {1'b0, start_f} + 33'd1);
    if (opcode == OP_MARK) begin
      push_entry.kind = K_MARK;
    end else if (reversed || !start_in) begin
      push_entry.kind = K_FIXED;
    end else begin
      push_entry.kind = K_WALK;
    end
  end

  assign in_ready = !q_stat.full && !clearing;

  // marks outside the store are dropped here
  assign push = in_valid && in_ready && !(opcode == OP_MARK && !start_in);

endmodule

// ===== hw/rtl/cct_queue.sv =====
module cct_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cct_pkg::entry_t  push_entry,
  input  logic             pop,
  output cct_pkg::entry_t  head,
  output cct_pkg::q_stat_t q_stat
);
  import cct_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = slots[rd_ptr];
  assign q_stat.full  = count == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;

endmodule

// ===== hw/rtl/cct_back.sv =====
module cct_back (
  input  logic             clk,
  input  logic             rst,
  input  cct_pkg::entry_t  head,
  input  cct_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [32:0]      covered_bytes,
  output logic [32:0]      region_bytes
);
  import cct_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_WALK   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [7:0]          store [STORE_BYTES];
  logic [7:0]          rdata;
  logic                we;
  logic [STORE_AW-1:0] wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [STORE_AW-1:0] rd_addr;
  logic [STORE_AW-1:0] clr_cnt;
  logic [STORE_AW-1:0] pos;
  logic [31:0]         stop;
  logic [32:0]         region;
  logic [STORE_AW:0]   cov;
  logic [STORE_AW:0]   cov_next;
  logic [STORE_AW:0]   pos_w;
  logic [STORE_AW:0]   pos_sum;
  logic [STORE_AW:0]   pos_next;
  logic                over;
  logic [7:0]          add;
  logic                walk_on;
  logic                out_free;

  // length store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  // one walk step on the byte just read
  always_comb begin
    pos_w    = {1'b0, pos};
    pos_sum  = pos_w + (STORE_AW+1)'(rdata);
    over     = 32'(pos_sum) > stop;
    pos_next = pos_sum;
    add      = rdata;
    walk_on  = 1'b1;
    if (rdata == 8'd0) begin
      pos_next = pos_w + 1'b1;
    end else if (over) begin
      // clip at the region end
      add     = 8'(stop - 32'(pos)) + 8'd1;
      walk_on = 1'b0;
    end
    if (32'(pos_next) > stop || pos_next[STORE_AW]) begin
      walk_on = 1'b0;
    end
    cov_next = cov + (STORE_AW+1)'(add);
  end

  assign out_free = !out_valid || out_ready;
  assign clearing = state == S_CLEAR;

  // sequencer control
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    wr_addr    = head.addr;
    wr_data    = head.len;
    rd_en      = 1'b0;
    rd_addr    = head.addr;
    case (state)
      S_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_cnt;
        wr_data = 8'd0;
        if (clr_cnt == STORE_AW'(STORE_BYTES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (head.kind)
            K_MARK: begin
              we = 1'b1;
            end
            K_WALK: begin
              rd_en      = 1'b1;
              state_next = S_WALK;
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end
      S_WALK: begin
        if (walk_on) begin
          rd_en   = 1'b1;
          rd_addr = pos_next[STORE_AW-1:0];
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == S_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && pop) begin
      pos    <= head.addr;
      stop   <= head.stop;
      region <= head.region;
      cov    <= '0;
    end else if (state == S_WALK) begin
      pos <= pos_next[STORE_AW-1:0];
      cov <= cov_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      covered_bytes <= 33'(cov);
      region_bytes  <= region;
    end
  end

endmodule

// ===== hw/rtl/code_coverage_tracker_unit.sv =====
// Execution coverage tracker over a 64 KiB byte store of instruction lengths.
// After reset the store is zeroed by a clearing pass, one byte a cycle, during
// which in_ready stays low; the mode register can be written throughout. A
// mark beat writes one length byte, so a trace can stream marks at one per
// cycle while no measure beat holds the walker. A measure beat walks its
// region through the single store read port at one step per cycle, where a
// step is one zero byte or one marked instruction. A four-entry command queue
// sits between the input side and the walker, and the result register holds
// one finished result while the next commands are taken.
module code_coverage_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        paged_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] address,
  input  logic [7:0]  op_length,
  input  logic [31:0] region_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [32:0] covered_bytes,
  output logic [32:0] region_bytes
);
  import cct_pkg::*;

  entry_t  push_entry;
  entry_t  head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    clearing;

  // intake and classification
  cct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .paged_mode (paged_mode),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .address    (address),
    .op_length  (op_length),
    .region_end (region_end),
    .q_stat     (q_stat),
    .clearing   (clearing),
    .push       (push),
    .push_entry (push_entry)
  );

  // command queue
  cct_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // store, walker and result register
  cct_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .covered_bytes (covered_bytes),
    .region_bytes  (region_bytes)
  );

endmodule

// ===== hw/rtl/cct_checker.sv =====
module cct_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [32:0] covered_bytes,
  input logic [32:0] region_bytes
);

  // in_ready is low just after reset, where the clearing pass of the store begins
  a_clear_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input taken during clearing pass");

  // a stalled result stays put
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(covered_bytes)
                                && $stable(region_bytes))
    else $error("result changed while stalled");

  // coverage never exceeds the region
  a_cover_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> covered_bytes <= region_bytes)
    else $error("covered bytes exceed region size");

  // an empty region covers nothing
  a_empty_region: assert property (@(posedge clk) disable iff (rst)
    out_valid && region_bytes == 33'd0 |-> covered_bytes == 33'd0)
    else $error("empty region reports coverage");

endmodule

bind code_coverage_tracker_unit cct_checker u_cct_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .covered_bytes (covered_bytes),
  .region_bytes  (region_bytes)
);
